// ----- rtl/hsp_pkg.sv -----
// ----------------------------------------------------------------------------
// hsp_pkg
// Shared types, widths and constants of the harmonic-sum pitch detector.
// ----------------------------------------------------------------------------
package hsp_pkg;

  // Default sizing of the top level
  localparam int unsigned MAX_BINS_DEF  = 4096;
  localparam int unsigned HARMONICS_DEF = 6;

  // Fixed field widths
  localparam int unsigned PWR_W   = 32;  // single bin power
  localparam int unsigned SUM_W   = 34;  // harmonic power sum
  localparam int unsigned PEAK_W  = 12;  // reported peak bin
  localparam int unsigned PITCH_W = 20;  // pitch in Q4 Hz
  localparam int unsigned CAND_W  = 15;  // candidate bin, below 2^14
  localparam int unsigned IDX_W   = 17;  // harmonic index and frame size
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned PROD_W  = RATE_W + CAND_W;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned APB_AW  = 5;

  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
  localparam logic [PITCH_W-1:0] PITCH_MAX = '1;

  // Register reset values
  localparam logic [11:0] RST_LOWEST_BIN  = 12'd5;
  localparam logic [12:0] RST_HIGHEST_BIN = 13'd4096;
  localparam logic [31:0] RST_THRESHOLD   = 32'd0;
  localparam logic [15:0] RST_SAMPLE_RATE = 16'd22050;
  localparam logic [3:0]  RST_LOG2_SIZE   = 4'd12;
  localparam logic [19:0] RST_BOUND_LOW   = 20'd1480;
  localparam logic [19:0] RST_BOUND_MID   = 20'd2217;
  localparam logic [19:0] RST_BOUND_HIGH  = 20'd3322;

  // Register index, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_LOWEST_BIN,
    REG_HIGHEST_BIN,
    REG_THRESHOLD,
    REG_SAMPLE_RATE,
    REG_LOG2_SIZE,
    REG_BOUND_LOW,
    REG_BOUND_MID,
    REG_BOUND_HIGH
  } hsp_reg_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_SEARCH,
    ST_DRAIN,
    ST_MUL,
    ST_PITCH,
    ST_DONE
  } hsp_state_e;

endpackage

// ----- rtl/harmonic_sum_pitch_detector.sv -----
// ----------------------------------------------------------------------------
// harmonic_sum_pitch_detector
// Loads a frame of complex bins into a RAM, then sweeps candidate bins,
// summing the power of each candidate and its harmonics, and reports the
// strongest candidate with its pitch and string class.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+---------------------------------
//  s_axis   | in  | tvalid/tready          | tdata re/im, tlast last bin
//  m_axis   | out | tvalid/tready          | tdata result, tuser frame error
//  apb      | in  | psel/penable/pready    | 8 registers at 4*index
//
//  Load: one bin per cycle into the bin RAM while in the load state.
//  Search: one RAM read per cycle, one read per harmonic (for each candidate,
//  the harmonics below the frame size), after the INIT setup state; then
//  the pipeline drains in DRAIN, and MUL, PITCH and DONE handle pitch,
//  class and result load.
//  Reset clears control state only; the bin RAM needs no clearing pass.
//  Input stalls from the last bin until the result is loaded; a held result
//  stalls only the next frame's result load.
// ----------------------------------------------------------------------------
module harmonic_sum_pitch_detector #(
  parameter int unsigned MAX_BINS  = hsp_pkg::MAX_BINS_DEF,
  parameter int unsigned HARMONICS = hsp_pkg::HARMONICS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // s_axis_tdata: bin_real [15:0], bin_imag [31:16]
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [hsp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tlast,
  // m_axis_tdata: detected [0], string_class [2:1], peak_bin [14:3],
  //   peak_sum [48:15], top_power [80:49], pitch_q4 [100:81], zero fill
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [hsp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // m_axis_tuser: frame_error [0]
  output logic [0:0]                       m_axis_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hsp_pkg::APB_AW-1:0]       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  import hsp_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_BINS);
  localparam int unsigned CNT_W = $clog2(MAX_BINS + 2);
  localparam int unsigned HW    = $clog2(HARMONICS + 1);
  localparam int unsigned ACC_W = (33 + $clog2(HARMONICS) > SUM_W) ?
                                  33 + $clog2(HARMONICS) : SUM_W;
  localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // Configuration
  logic [11:0]        cfg_lowest_q;
  logic [12:0]        cfg_highest_q;
  logic [31:0]        cfg_thresh_q;
  logic [RATE_W-1:0]  cfg_rate_q;
  logic [3:0]         cfg_log2_q;
  logic [19:0]        cfg_blow_q;
  logic [19:0]        cfg_bmid_q;
  logic [19:0]        cfg_bhigh_q;
  logic               cfg_wr;
  hsp_reg_e           reg_sel;

  hsp_state_e         state_q, state_d;

  logic [CNT_W-1:0]   cnt_q, cnt_inc, held;
  logic               err_q;
  logic               s_fire;

  logic [IDX_W-1:0]   n_ext, half;
  logic [CAND_W-1:0]  cand_q, cand_nxt;
  logic [IDX_W-1:0]   idx_q, idx_nxt;
  logic [HW-1:0]      h_q;
  logic               last_h, init_ok, nxt_ok, rng;

  logic [IN_DATA_W-1:0] ram_rdata;

  logic               s1_vld_q, s1_rng_q, s1_first_q, s1_last_q;
  logic [CAND_W-1:0]  s1_cand_q;
  logic               s2_vld_q, s2_first_q, s2_last_q;
  logic [CAND_W-1:0]  s2_cand_q;
  logic [PWR_W-1:0]   s2_pow_q;
  logic [ACC_W-1:0]   acc_q;
  logic               cmp_vld_q;
  logic [CAND_W-1:0]  cmp_cand_q;

  logic signed [31:0] re_sq, im_sq;
  logic [PWR_W-1:0]   pow;
  logic [SUM_W-1:0]   acc_sat;

  logic [SUM_W-1:0]   best_sum_q;
  logic [CAND_W-1:0]  best_bin_q;
  logic [PWR_W-1:0]   best_single_q;

  logic [PROD_W-1:0]  prod_q;
  logic [PROD_W+3:0]  pitch_wide;
  logic [PITCH_W-1:0] pitch_q;
  logic [1:0]         cls;
  logic               det;

  logic               out_vld_q, out_free, out_load;
  logic               o_det_q, o_err_q;
  logic [1:0]         o_cls_q;
  logic [PEAK_W-1:0]  o_bin_q;
  logic [SUM_W-1:0]   o_sum_q;
  logic [PWR_W-1:0]   o_single_q;
  logic [PITCH_W-1:0] o_pitch_q;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = hsp_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_lowest_q  <= RST_LOWEST_BIN;
      cfg_highest_q <= RST_HIGHEST_BIN;
      cfg_thresh_q  <= RST_THRESHOLD;
      cfg_rate_q    <= RST_SAMPLE_RATE;
      cfg_log2_q    <= RST_LOG2_SIZE;
      cfg_blow_q    <= RST_BOUND_LOW;
      cfg_bmid_q    <= RST_BOUND_MID;
      cfg_bhigh_q   <= RST_BOUND_HIGH;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_LOWEST_BIN:  cfg_lowest_q  <= pwdata[11:0];
        REG_HIGHEST_BIN: cfg_highest_q <= pwdata[12:0];
        REG_THRESHOLD:   cfg_thresh_q  <= pwdata;
        REG_SAMPLE_RATE: cfg_rate_q    <= pwdata[15:0];
        REG_LOG2_SIZE:   cfg_log2_q    <= pwdata[3:0];
        REG_BOUND_LOW:   cfg_blow_q    <= pwdata[19:0];
        REG_BOUND_MID:   cfg_bmid_q    <= pwdata[19:0];
        REG_BOUND_HIGH:  cfg_bhigh_q   <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LOWEST_BIN:  prdata = 32'(cfg_lowest_q);
      REG_HIGHEST_BIN: prdata = 32'(cfg_highest_q);
      REG_THRESHOLD:   prdata = cfg_thresh_q;
      REG_SAMPLE_RATE: prdata = 32'(cfg_rate_q);
      REG_LOG2_SIZE:   prdata = 32'(cfg_log2_q);
      REG_BOUND_LOW:   prdata = 32'(cfg_blow_q);
      REG_BOUND_MID:   prdata = 32'(cfg_bmid_q);
      REG_BOUND_HIGH:  prdata = 32'(cfg_bhigh_q);
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Frame load
  // --------------------------------------------------------------------------
  assign s_axis_tready = (state_q == ST_LOAD);
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  // Count saturates one past the store depth so an overlong frame is flagged
  assign cnt_inc = (cnt_q <= CNT_W'(MAX_BINS)) ? cnt_q + 1'b1 : cnt_q;
  assign held    = (cnt_q > CNT_W'(MAX_BINS)) ? CNT_W'(MAX_BINS) : cnt_q;

  assign n_ext = IDX_W'(1) << cfg_log2_q;
  assign half  = n_ext >> 1;

  // --------------------------------------------------------------------------
  // Search sequencer: one harmonic read per cycle
  // --------------------------------------------------------------------------
  assign idx_nxt  = idx_q + IDX_W'(cand_q);
  assign last_h   = (h_q == HW'(HARMONICS)) || (idx_nxt >= n_ext);
  assign cand_nxt = cand_q + 1'b1;
  assign init_ok  = (IDX_W'(cfg_lowest_q) < half) &&
                    (CAND_W'(cfg_lowest_q) < CAND_W'(cfg_highest_q));
  assign nxt_ok   = (IDX_W'(cand_nxt) < half) &&
                    (cand_nxt < CAND_W'(cfg_highest_q));
  // Bins past the received count read as zero power
  assign rng      = CMP_W'(idx_q) < CMP_W'(held);

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (s_fire && s_axis_tlast) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        state_d = init_ok ? ST_SEARCH : ST_DRAIN;
      end
      ST_SEARCH: begin
        if (last_h && !nxt_ok) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_q && !s2_vld_q && !cmp_vld_q) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_PITCH;
      end
      ST_PITCH: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      err_q   <= 1'b0;
      cand_q  <= '0;
      idx_q   <= '0;
      h_q     <= '0;
    end else begin
      state_q <= state_d;
      if (s_fire) begin
        cnt_q <= cnt_inc;
        if (s_axis_tlast) begin
          err_q <= CMP_W'(cnt_inc) != CMP_W'(n_ext);
        end
      end else if (out_load) begin
        cnt_q <= '0;
      end
      if (state_q == ST_INIT) begin
        cand_q <= CAND_W'(cfg_lowest_q);
        idx_q  <= IDX_W'(cfg_lowest_q);
        h_q    <= HW'(1);
      end else if (state_q == ST_SEARCH) begin
        if (last_h) begin
          cand_q <= cand_nxt;
          idx_q  <= IDX_W'(cand_nxt);
          h_q    <= HW'(1);
        end else begin
          idx_q  <= idx_nxt;
          h_q    <= h_q + 1'b1;
        end
      end
    end
  end

  hsp_ram #(
    .WIDTH (IN_DATA_W),
    .DEPTH (MAX_BINS)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (s_fire && (cnt_q < CNT_W'(MAX_BINS))),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .re_i    ((state_q == ST_SEARCH) && rng),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Power, accumulate, compare pipeline
  // --------------------------------------------------------------------------
  assign re_sq   = $signed(ram_rdata[15:0]) * $signed(ram_rdata[15:0]);
  assign im_sq   = $signed(ram_rdata[31:16]) * $signed(ram_rdata[31:16]);
  assign pow     = $unsigned(re_sq) + $unsigned(im_sq);
  assign acc_sat = (acc_q > ACC_W'(SUM_MAX)) ? SUM_MAX : acc_q[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q      <= 1'b0;
      s2_vld_q      <= 1'b0;
      cmp_vld_q     <= 1'b0;
      best_sum_q    <= '0;
      best_bin_q    <= '0;
      best_single_q <= '0;
    end else begin
      s1_vld_q  <= (state_q == ST_SEARCH);
      s2_vld_q  <= s1_vld_q;
      cmp_vld_q <= s2_vld_q & s2_last_q;
      if (state_q == ST_INIT) begin
        best_sum_q    <= '0;
        best_bin_q    <= '0;
        best_single_q <= '0;
      end else begin
        if (s2_vld_q && (s2_pow_q > best_single_q)) begin
          best_single_q <= s2_pow_q;
        end
        // Strict compare keeps the lowest candidate on ties
        if (cmp_vld_q && (acc_sat > best_sum_q)) begin
          best_sum_q <= acc_sat;
          best_bin_q <= cmp_cand_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_rng_q   <= rng;
    s1_first_q <= (h_q == HW'(1));
    s1_last_q  <= last_h;
    s1_cand_q  <= cand_q;
    s2_pow_q   <= s1_rng_q ? pow : '0;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_cand_q  <= s1_cand_q;
    if (s2_vld_q) begin
      acc_q <= (s2_first_q ? '0 : acc_q) + ACC_W'(s2_pow_q);
    end
    cmp_cand_q <= s2_cand_q;
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(cfg_rate_q * best_bin_q);
    end
    if (state_q == ST_PITCH) begin
      pitch_q <= (pitch_wide > (PROD_W+4)'(PITCH_MAX)) ? PITCH_MAX
                                                       : pitch_wide[PITCH_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Pitch, class and result register
  // --------------------------------------------------------------------------
  assign pitch_wide = {prod_q, 4'b0000} >> cfg_log2_q;
  assign det        = best_single_q > cfg_thresh_q;

  always_comb begin
    if (pitch_q < cfg_blow_q) begin
      cls = 2'd0;
    end else if (pitch_q < cfg_bmid_q) begin
      cls = 2'd1;
    end else if (pitch_q < cfg_bhigh_q) begin
      cls = 2'd2;
    end else begin
      cls = 2'd3;
    end
  end

  assign out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_err_q    <= err_q;
      o_det_q    <= det;
      // Drop every result field when nothing was detected
      o_cls_q    <= det ? cls : '0;
      o_bin_q    <= det ? best_bin_q[PEAK_W-1:0] : '0;
      o_sum_q    <= det ? best_sum_q : '0;
      o_single_q <= det ? best_single_q : '0;
      o_pitch_q  <= det ? pitch_q : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, o_pitch_q, o_single_q, o_sum_q, o_bin_q, o_cls_q, o_det_q};
  assign m_axis_tuser  = o_err_q;

endmodule

// ----- rtl/hsp_ram.sv -----
// ----------------------------------------------------------------------------
// hsp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/hsp_checker.sv -----
// ----------------------------------------------------------------------------
// hsp_checker
// Port-level checks of the pitch detector, bound to the top level.
// ----------------------------------------------------------------------------
module hsp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [hsp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  import hsp_pkg::*;

  // A held result keeps its valid and payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item dropped or changed while stalled");

  // The last bin of a frame starts the search, so input stalls next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input accepted right after the last bin");

  // No detection leaves every result field at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[100:1] == '0)
    else $error("result fields set without detection");

  // The winning sum can never be below the strongest single bin, which is nonzero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
      m_axis_tdata[48:15] >= SUM_W'(m_axis_tdata[80:49]) &&
      m_axis_tdata[80:49] != '0)
    else $error("peak sum below max single power");

endmodule

bind harmonic_sum_pitch_detector hsp_checker u_hsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/harmonic_sum_pitch_detector_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// harmonic_sum_pitch_detector_tb
// Streams frames of complex bins into the pitch detector under a range of
// register settings, predicts each frame's pitch report and compares every
// report field by field. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module harmonic_sum_pitch_detector_tb;
  import hsp_pkg::*;

  localparam int          MAX_BINS    = MAX_BINS_DEF;
  localparam int          HARMONICS   = HARMONICS_DEF;
  localparam int          TOTAL_ITEMS = 1550;
  localparam int          LONG_HOLD   = 2500;
  localparam int          DRAIN_SLACK = 16;
  localparam longint      CYCLE_LIMIT = 2_000_000;

  typedef enum int {FR_NOISE, FR_TONE, FR_QUIET, FR_EXTREME, FR_SILENT} frame_style_e;
  typedef enum int {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_e;

  typedef struct {
    logic [15:0] re;
    logic [15:0] im;
    logic        last;
  } spectrum_bin_t;

  typedef struct {
    logic        detected;
    logic [1:0]  string_class;
    logic [11:0] peak_bin;
    logic [33:0] peak_sum;
    logic [31:0] top_power;
    logic [19:0] pitch_q4;
    logic        frame_error;
  } pitch_report_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  s_axis_tvalid  = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata   = '0;
  logic                  s_axis_tlast   = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [APB_AW-1:0]     paddr          = '0;
  logic [31:0]           pwdata         = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Predictor state: register copy, bin memory and frame position
  logic [31:0]   det_regs [8];
  logic [31:0]   bin_mem [MAX_BINS];
  int unsigned   bins_in_frame = 0;

  spectrum_bin_t bin_feed [$];
  pitch_report_t expected_reports [$];
  spectrum_bin_t feed_now;
  pitch_report_t want;

  int     n_errors         = 0;
  int     bins_queued      = 0;
  int     bins_accepted    = 0;
  int     frames_queued    = 0;
  int     settings_applied = 0;
  int     reports_checked  = 0;
  int     reports_detected = 0;
  int     reports_flagged  = 0;
  longint cycle_count      = 0;

  logic     bin_taken = 1'b0;
  int       gap_left = 0;
  int       burst_left = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_e rx_mode = RX_ALWAYS;
  logic     ready_next;
  logic     long_hold_req = 1'b0;
  logic     long_hold_used = 1'b0;

  harmonic_sum_pitch_detector #(
    .MAX_BINS  (MAX_BINS),
    .HARMONICS (HARMONICS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] reg_mask(hsp_reg_e r);
    case (r)
      REG_LOWEST_BIN:  return 32'h0000_0FFF;
      REG_HIGHEST_BIN: return 32'h0000_1FFF;
      REG_THRESHOLD:   return 32'hFFFF_FFFF;
      REG_SAMPLE_RATE: return 32'h0000_FFFF;
      REG_LOG2_SIZE:   return 32'h0000_000F;
      REG_BOUND_LOW, REG_BOUND_MID, REG_BOUND_HIGH: return 32'h000F_FFFF;
      default:         return 32'h0;
    endcase
  endfunction

  // Bins outside the part of the frame received and stored count as silent
  function automatic longint unsigned bin_power(longint unsigned idx);
    longint unsigned held;
    longint          re;
    longint          im;
    held = (bins_in_frame < MAX_BINS) ? bins_in_frame : MAX_BINS;
    if (idx >= held) return 0;
    re = $signed(bin_mem[idx][15:0]);
    im = $signed(bin_mem[idx][31:16]);
    return re * re + im * im;
  endfunction

  function automatic pitch_report_t predict_pitch_report();
    pitch_report_t   rep;
    longint unsigned n, lo, hi, i, h, p, sum;
    longint unsigned best_sum, best_bin, best_single, pitch;
    int unsigned     lg;
    rep = '{default: '0};
    lg  = det_regs[REG_LOG2_SIZE][3:0];
    n   = 64'd1 << lg;
    lo  = det_regs[REG_LOWEST_BIN][11:0];
    hi  = det_regs[REG_HIGHEST_BIN][12:0];
    best_sum = 0;
    best_bin = 0;
    best_single = 0;
    for (i = lo; i < n / 2 && i < hi; i++) begin
      sum = 0;
      for (h = 1; h <= HARMONICS && i * h < n; h++) begin
        p = bin_power(i * h);
        sum += p;
        if (p > best_single) best_single = p;
      end
      if (sum > SUM_MAX) sum = SUM_MAX;
      // strict compare: the lowest candidate keeps a tie
      if (sum > best_sum) begin
        best_sum = sum;
        best_bin = i;
      end
    end
    rep.frame_error = (bins_in_frame != n);
    if (best_single > det_regs[REG_THRESHOLD]) begin
      pitch = ((longint'(det_regs[REG_SAMPLE_RATE][15:0]) * best_bin) << 4) >> lg;
      if (pitch > PITCH_MAX) pitch = PITCH_MAX;
      rep.detected   = 1'b1;
      rep.peak_bin   = best_bin[11:0];
      rep.peak_sum   = best_sum[33:0];
      rep.top_power  = best_single[31:0];
      rep.pitch_q4   = pitch[19:0];
      if (pitch < det_regs[REG_BOUND_LOW][19:0]) rep.string_class = 2'd0;
      else if (pitch < det_regs[REG_BOUND_MID][19:0]) rep.string_class = 2'd1;
      else if (pitch < det_regs[REG_BOUND_HIGH][19:0]) rep.string_class = 2'd2;
      else rep.string_class = 2'd3;
    end
    return rep;
  endfunction

  function automatic void take_bin(logic [31:0] word, logic last);
    if (bins_in_frame < MAX_BINS) bin_mem[bins_in_frame] = word;
    if (bins_in_frame <= MAX_BINS) bins_in_frame++;
    if (last) begin
      expected_reports.push_back(predict_pitch_report());
      bins_in_frame = 0;
    end
  endfunction

  function automatic void check_field(string label, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", label, exp_v, got_v);
      n_errors++;
    end
  endfunction

  task automatic push_bin(int re, int im, logic last);
    spectrum_bin_t b;
    b.re   = re[15:0];
    b.im   = im[15:0];
    b.last = last;
    bin_feed.push_back(b);
    bins_queued++;
  endtask

  task automatic queue_frame(int nbins, frame_style_e style);
    int extreme_vals [5] = '{-32768, 32767, 0, -1, 1};
    int f0, k, re, im;
    f0 = $urandom_range(1, (nbins > 3) ? nbins / 2 : 1);
    for (k = 0; k < nbins; k++) begin
      case (style)
        FR_NOISE: begin
          re = $urandom;
          im = $urandom;
        end
        FR_TONE: begin
          // strong fundamental and harmonics over a faint floor
          re = int'($urandom_range(0, 6)) - 3;
          im = int'($urandom_range(0, 6)) - 3;
          if (k % f0 == 0 && k / f0 >= 1 && k / f0 <= HARMONICS) begin
            re = $urandom_range(0, 32767);
            im = $urandom_range(0, 32767);
            if ($urandom_range(0, 1)) re = -re;
            if ($urandom_range(0, 1)) im = -im;
          end
        end
        FR_QUIET: begin
          re = int'($urandom_range(0, 40)) - 20;
          im = int'($urandom_range(0, 40)) - 20;
        end
        FR_EXTREME: begin
          re = extreme_vals[$urandom_range(0, 4)];
          im = extreme_vals[$urandom_range(0, 4)];
        end
        default: begin
          re = 0;
          im = 0;
        end
      endcase
      push_bin(re, im, k == nbins - 1);
    end
    frames_queued++;
  endtask

  task automatic apb_write(hsp_reg_e r, logic [31:0] v);
    if ($urandom_range(0, 3) == 0) v = v | ($urandom & ~reg_mask(r));
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    det_regs[r] = v & reg_mask(r);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check(hsp_reg_e r);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== det_regs[r]) begin
      $error("%s readback: expected %0h, got %0h", r.name(), det_regs[r], prdata);
      n_errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_cfg(logic [31:0] vals [8]);
    for (int k = 0; k < 8; k++) begin
      apb_write(hsp_reg_e'(k), vals[k]);
      apb_check(hsp_reg_e'(k));
    end
    settings_applied++;
  endtask

  // Hold until every queued bin is taken and every report has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (!(bins_accepted == bins_queued && expected_reports.size() == 0));
    repeat (DRAIN_SLACK) @(negedge clk_i);
  endtask

  // Sender: bursts of random length, random gaps, now and then a long run
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || bin_taken) begin
      if (gap_left > 0 || bin_feed.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        feed_now = bin_feed.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {feed_now.im, feed_now.re};
        s_axis_tlast  <= feed_now.last;
        burst_left--;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = 300;
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Receiver: stall pattern switches between random modes, with one long hold on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (long_hold_req && !long_hold_used) begin
        long_hold_used = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (mode_left <= 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: ready_next = 1'b1;
          RX_HALF:   ready_next = $urandom_range(0, 1);
          RX_MOSTLY: ready_next = ($urandom_range(0, 9) != 0);
          default:   ready_next = ($urandom_range(0, 7) == 0);
        endcase
      end
      m_axis_tready <= ready_next;
    end
  end

  always @(posedge clk_i) begin
    bin_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      take_bin(s_axis_tdata, s_axis_tlast);
      bins_accepted++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        $error("pitch report arrived with none expected");
        n_errors++;
      end else begin
        want = expected_reports.pop_front();
        check_field("detected", want.detected, m_axis_tdata[0]);
        check_field("string_class", want.string_class, m_axis_tdata[2:1]);
        check_field("peak_bin", want.peak_bin, m_axis_tdata[14:3]);
        check_field("peak_sum", want.peak_sum, m_axis_tdata[48:15]);
        check_field("top_power", want.top_power, m_axis_tdata[80:49]);
        check_field("pitch_q4", want.pitch_q4, m_axis_tdata[100:81]);
        check_field("frame_error", want.frame_error, m_axis_tuser[0]);
        reports_checked++;
        if (want.detected) reports_detected++;
        if (want.frame_error) reports_flagged++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped at cycle limit %0d, %0d reports outstanding",
               CYCLE_LIMIT, expected_reports.size());
      $display("** harmonic_sum_pitch_detector: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [31:0] cfg [8];
    logic [19:0] bnd [3];
    logic [19:0] swap;
    int          r, lg, n, nb;
    int unsigned rate;
    frame_style_e style;

    det_regs[REG_LOWEST_BIN]  = 32'(RST_LOWEST_BIN);
    det_regs[REG_HIGHEST_BIN] = 32'(RST_HIGHEST_BIN);
    det_regs[REG_THRESHOLD]   = 32'(RST_THRESHOLD);
    det_regs[REG_SAMPLE_RATE] = 32'(RST_SAMPLE_RATE);
    det_regs[REG_LOG2_SIZE]   = 32'(RST_LOG2_SIZE);
    det_regs[REG_BOUND_LOW]   = 32'(RST_BOUND_LOW);
    det_regs[REG_BOUND_MID]   = 32'(RST_BOUND_MID);
    det_regs[REG_BOUND_HIGH]  = 32'(RST_BOUND_HIGH);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int k = 0; k < 8; k++) apb_check(hsp_reg_e'(k));

    // Reset settings: short frame with extreme bins, three tied candidates
    push_bin(-32768, -32768, 1'b0);
    push_bin(32767, 32767, 1'b0);
    push_bin(-32768, 32767, 1'b0);
    push_bin(0, -1, 1'b0);
    push_bin(1, 0, 1'b0);
    push_bin(3, 4, 1'b0);
    push_bin(4, 3, 1'b0);
    push_bin(-5, 0, 1'b1);
    // single-bin frame, then a silent one that must not detect
    push_bin(-32768, -32768, 1'b1);
    queue_frame(4, FR_SILENT);
    frames_queued++;
    frames_queued++;
    wait_drained();

    // Tiny frames, down to one bin, every candidate from bin zero
    for (int k = 0; k < 4; k++) begin
      cfg = '{32'd0, 32'd8191, 32'd0, $urandom_range(1, 65535), k, 32'd100, 32'd200, 32'd300};
      program_cfg(cfg);
      queue_frame(1 << k, FR_NOISE);
      queue_frame((1 << k) + 1, FR_EXTREME);
      wait_drained();
    end

    // Frame setting equal to the bin memory depth, with short frames that fall well below it
    cfg = '{32'd0, 32'd4096, 32'd1000, 32'd48000, 32'd12, 32'd1000, 32'd20000, 32'd40000};
    program_cfg(cfg);
    queue_frame(200, FR_TONE);
    queue_frame(50, FR_NOISE);
    wait_drained();

    // Frame sizes beyond the bin memory: candidates reach unreceived bins
    cfg = '{32'd0, 32'd8191, 32'h7FFF_FFFF, 32'd8000, 32'd13, 32'd0, 32'd5000, 32'd9000};
    program_cfg(cfg);
    queue_frame(100, FR_EXTREME);
    wait_drained();
    cfg = '{32'd20, 32'd8191, 32'd0, 32'd65535, 32'd14, 32'd500, 32'd600, 32'd700};
    program_cfg(cfg);
    queue_frame(120, FR_TONE);
    wait_drained();
    cfg = '{32'd4095, 32'd8191, 32'd0, 32'd65535, 32'd15, 32'd0, 32'd0, 32'd1048575};
    program_cfg(cfg);
    queue_frame(80, FR_NOISE);
    wait_drained();

    // No candidate at all: first bin past half the frame, then empty range
    cfg = '{32'd40, 32'd8191, 32'd0, 32'd22050, 32'd6, 32'd1480, 32'd2217, 32'd3322};
    program_cfg(cfg);
    queue_frame(64, FR_NOISE);
    wait_drained();
    cfg = '{32'd0, 32'd0, 32'd0, 32'd22050, 32'd6, 32'd1480, 32'd2217, 32'd3322};
    program_cfg(cfg);
    queue_frame(64, FR_NOISE);
    wait_drained();

    // Receiver holds off while frames keep coming, so the input backs up
    cfg = '{32'd0, 32'd8191, 32'd0, 32'd44100, 32'd6, 32'd2000, 32'd4000, 32'd8000};
    program_cfg(cfg);
    long_hold_req = 1'b1;
    repeat (4) queue_frame(64, FR_TONE);
    wait_drained();

    while (bins_queued < TOTAL_ITEMS) begin
      r  = $urandom_range(0, 99);
      lg = (r < 60) ? 6 : (r < 85) ? 7 : (r < 95) ? 8 : $urandom_range(0, 5);
      n  = 1 << lg;
      cfg[REG_LOG2_SIZE] = lg;
      r = $urandom_range(0, 99);
      cfg[REG_LOWEST_BIN] = (r < 70) ? $urandom_range(0, n / 4) :
                            (r < 90) ? $urandom_range(0, n / 2) : $urandom_range(0, 4095);
      r = $urandom_range(0, 99);
      cfg[REG_HIGHEST_BIN] = (r < 50) ? $urandom_range(n / 2, 8191) :
                             (r < 80) ? $urandom_range(0, n / 2) : (r < 95) ? 4096 : 0;
      r = $urandom_range(0, 99);
      cfg[REG_THRESHOLD] = (r < 40) ? 32'd0 : (r < 70) ? $urandom_range(0, 1 << 20) :
                           (r < 85) ? $urandom : (r < 90) ? 32'h8000_0000 :
                           (r < 95) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
      r = $urandom_range(0, 99);
      rate = (r < 10) ? 1 : (r < 20) ? 65535 : (r < 23) ? 0 : $urandom_range(1, 65535);
      cfg[REG_SAMPLE_RATE] = rate;
      // bounds spread over the reachable pitch range, mostly in order
      r = $urandom_range(0, 99);
      for (int k = 0; k < 3; k++)
        bnd[k] = (r < 5) ? 20'($urandom) : 20'($urandom_range(0, rate * 8 + 16));
      if (r >= 15) begin
        if (bnd[0] > bnd[1]) begin swap = bnd[0]; bnd[0] = bnd[1]; bnd[1] = swap; end
        if (bnd[1] > bnd[2]) begin swap = bnd[1]; bnd[1] = bnd[2]; bnd[2] = swap; end
        if (bnd[0] > bnd[1]) begin swap = bnd[0]; bnd[0] = bnd[1]; bnd[1] = swap; end
      end
      cfg[REG_BOUND_LOW]  = bnd[0];
      cfg[REG_BOUND_MID]  = bnd[1];
      cfg[REG_BOUND_HIGH] = bnd[2];
      program_cfg(cfg);

      repeat ($urandom_range(2, 5)) begin
        if (bins_queued < TOTAL_ITEMS) begin
          r  = $urandom_range(0, 9);
          nb = (r == 0 && n > 1) ? $urandom_range(1, n - 1) :
               (r == 1) ? n + $urandom_range(1, 8) : n;
          r  = $urandom_range(0, 19);
          style = (r < 8) ? FR_TONE : (r < 13) ? FR_NOISE : (r < 16) ? FR_QUIET :
                  (r < 18) ? FR_EXTREME : FR_SILENT;
          queue_frame(nb, style);
        end
      end
      wait_drained();
    end

    $display("Streamed %0d bins in %0d frames under %0d register settings, frame sizes 1 to 32768.",
             bins_accepted, frames_queued, settings_applied);
    $display("Checked %0d pitch reports: %0d detections, %0d with frame errors.",
             reports_checked, reports_detected, reports_flagged);
    if (n_errors == 0) begin
      $display("** harmonic_sum_pitch_detector: PASSED **");
    end else begin
      $display("** harmonic_sum_pitch_detector: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hsp_pkg.sv
rtl/hsp_ram.sv
rtl/harmonic_sum_pitch_detector.sv
rtl/hsp_checker.sv
tb/sv/harmonic_sum_pitch_detector_tb.sv
